// File: design/glyph_8x16_attribute_renderer_defines.svh
// Assertion macros for the glyph row renderer.
`ifndef GLYPH_8X16_ATTRIBUTE_RENDERER_DEFINES_SVH
`define GLYPH_8X16_ATTRIBUTE_RENDERER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define GAR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define GAR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/glyph_pkg.sv
// Types and constants for the glyph row renderer.
package glyph_pkg;

  localparam logic [7:0] MaskEven = 8'haa;
  localparam logic [7:0] MaskOdd  = 8'h55;
  localparam logic [7:0] RowFull  = 8'hff;
  localparam logic [7:0] LeftBit  = 8'h80;

  localparam logic [12:0] ScreenWidthReset  = 13'd320;
  localparam logic [12:0] ScreenHeightReset = 13'd240;

  localparam int unsigned Columns = 9;

  typedef enum logic {
    REG_SCREEN_WIDTH  = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    UL_NONE   = 2'd0,
    UL_SINGLE = 2'd1,
    UL_DOUBLE = 2'd2
  } underline_t;

  typedef enum logic [1:0] {
    SH_NONE    = 2'd0,
    SH_DIM     = 2'd1,
    SH_CONCEAL = 2'd2
  } shade_t;

  typedef struct packed {
    logic [1:0]  pad;
    logic [15:0] back_color;
    logic [15:0] fore_color;
    logic [12:0] cell_y;
    logic [12:0] cell_x;
    logic [7:0]  glyph_row;
    logic [3:0]  row_index;
  } in_data_t;

  typedef struct packed {
    logic       bold;
    logic       transparent;
    logic [1:0] shade_mode;
    logic [1:0] underline_mode;
    logic       framed;
    logic       reverse;
  } in_attr_t;

  typedef struct packed {
    logic [15:0] pixel_color;
    logic [11:0] pixel_y;
    logic [11:0] pixel_x;
  } out_data_t;

endpackage

// File: design/glyph_8x16_attribute_renderer.sv
// Top level of the glyph row renderer: row shaping, clipping and pixel emission.
//
//  channel  | dir | handshake                  | payload
//  ---------+-----+----------------------------+-------------------------------------
//  s_       | in  | s_tvalid / s_tready        | s_tdata glyph row, s_tuser attributes
//  m_       | out | m_tvalid / m_tready        | m_tdata pixel write, m_tlast end of row
//  apb      | in  | psel, penable, pready high | screen_width, screen_height
//
//  One pixel write leaves per cycle through the single output register; a row
//  holds the emitter for 1 to 9 writes, and a row with no write takes only its
//  input handshake. The next row is taken in the cycle its predecessor's last
//  write moves to the output register.
//  Reset is synchronous; it empties the emitter and the output register and
//  restores the screen size. A low m_tready holds the output and the emitter.
`include "glyph_8x16_attribute_renderer_defines.svh"

module glyph_8x16_attribute_renderer #(
  parameter int COORD_BITS = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // row_index, glyph_row, cell_x, cell_y, fore_color,
                                 // back_color, zero pad
  input  logic [7:0]  s_tuser,   // reverse, framed, underline_mode, shade_mode,
                                 // transparent, bold
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // pixel_x, pixel_y, pixel_color
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [11:0] CoordMask =
    (COORD_BITS >= 12) ? 12'hfff : 12'((1 << COORD_BITS) - 1);

  glyph_pkg::in_data_t  in_data;
  glyph_pkg::in_attr_t  in_attr;
  glyph_pkg::out_data_t out_data;

  logic [12:0] screen_width;
  logic [12:0] screen_height;

  logic [7:0]  shaped;
  logic [8:0]  lit_new;
  logic [8:0]  emit_new;
  logic        off_screen;
  logic        ninth_ok;
  logic signed [14:0] cx_ext;
  logic signed [14:0] cy_ext;
  logic signed [14:0] x_limit;
  logic signed [14:0] y_limit;

  logic        busy;
  logic [8:0]  rem;
  logic [8:0]  lit;
  logic [11:0] base_x;
  logic [11:0] base_y;
  logic [15:0] fg;
  logic [15:0] bg;

  logic [8:0]  rem_next;
  logic [3:0]  pick;
  logic        out_advance;
  logic        emit_fire;
  logic        in_fire;
  logic        cfg_write;

  assign in_data = s_tdata;
  assign in_attr = s_tuser;
  assign m_tdata = out_data;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (glyph_pkg::reg_idx_t'(paddr[2]))
      glyph_pkg::REG_SCREEN_WIDTH:  prdata = {19'd0, screen_width};
      glyph_pkg::REG_SCREEN_HEIGHT: prdata = {19'd0, screen_height};
      default:                      prdata = 32'd0;
    endcase
  end

  always_comb begin
    shaped = in_data.glyph_row;
    if (in_attr.framed) begin
      if (in_data.row_index == 4'd0) begin
        shaped = glyph_pkg::RowFull;
      end else begin
        shaped = shaped | 8'd1;
      end
    end
    case (in_attr.underline_mode)
      glyph_pkg::UL_NONE: begin
      end
      glyph_pkg::UL_DOUBLE: begin
        if (in_data.row_index == 4'd13 || in_data.row_index == 4'd15) begin
          shaped = glyph_pkg::RowFull;
        end
      end
      default: begin
        if (in_data.row_index == 4'd14 || in_data.row_index == 4'd15) begin
          shaped = glyph_pkg::RowFull;
        end
      end
    endcase
    case (in_attr.shade_mode)
      glyph_pkg::SH_NONE: begin
      end
      glyph_pkg::SH_CONCEAL: begin
        shaped = shaped | (in_data.row_index[0] ? glyph_pkg::MaskOdd : glyph_pkg::MaskEven);
      end
      default: begin
        shaped = shaped & (in_data.row_index[0] ? glyph_pkg::MaskOdd : glyph_pkg::MaskEven);
      end
    endcase
  end

  always_comb begin
    cx_ext     = {{2{in_data.cell_x[12]}}, in_data.cell_x};
    cy_ext     = {{2{in_data.cell_y[12]}}, in_data.cell_y};
    x_limit    = $signed({2'b00, screen_width}) - 15'sd8;
    y_limit    = $signed({2'b00, screen_height}) - 15'sd16;
    off_screen = in_data.cell_x[12] || in_data.cell_y[12] ||
                 (cx_ext > x_limit) || (cy_ext > y_limit);
    ninth_ok   = cx_ext < x_limit;
  end

  // Column 0 is the leftmost pixel, taken from the top bit of the row.
  always_comb begin
    for (int c = 0; c < 8; c++) begin
      lit_new[c] = (shaped & (glyph_pkg::LeftBit >> c)) != 8'd0;
    end
    lit_new[8] = 1'b0;
    for (int c = 1; c < 9; c++) begin
      if (in_attr.bold && (shaped & (glyph_pkg::LeftBit >> (c - 1))) != 8'd0) begin
        lit_new[c] = 1'b1;
      end
    end
    for (int c = 0; c < 8; c++) begin
      emit_new[c] = lit_new[c] || !in_attr.transparent;
    end
    emit_new[8] = lit_new[8] && ninth_ok;
    if (off_screen) begin
      emit_new = 9'd0;
    end
  end

  always_comb begin
    pick = 4'd0;
    for (int c = glyph_pkg::Columns - 1; c >= 0; c--) begin
      if (rem[c]) begin
        pick = 4'(c);
      end
    end
    rem_next = rem & (rem - 9'd1);
  end

  assign out_advance = !m_tvalid || m_tready;
  assign emit_fire   = busy && out_advance;
  assign s_tready    = !busy || (out_advance && rem_next == 9'd0);
  assign in_fire     = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      m_tvalid      <= 1'b0;
      screen_width  <= glyph_pkg::ScreenWidthReset;
      screen_height <= glyph_pkg::ScreenHeightReset;
    end else begin
      if (cfg_write) begin
        case (glyph_pkg::reg_idx_t'(paddr[2]))
          glyph_pkg::REG_SCREEN_WIDTH:  screen_width  <= pwdata[12:0];
          glyph_pkg::REG_SCREEN_HEIGHT: screen_height <= pwdata[12:0];
          default: begin
          end
        endcase
      end
      if (out_advance) begin
        m_tvalid <= busy;
      end
      if (in_fire) begin
        busy <= emit_new != 9'd0;
      end else if (emit_fire && rem_next == 9'd0) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_data.pixel_x     <= (base_x + 12'(pick)) & CoordMask;
      out_data.pixel_y     <= base_y & CoordMask;
      out_data.pixel_color <= lit[pick] ? fg : bg;
      m_tlast              <= rem_next == 9'd0;
    end
    if (in_fire) begin
      rem    <= emit_new;
      lit    <= lit_new;
      base_x <= in_data.cell_x[11:0];
      base_y <= in_data.cell_y[11:0] + {8'd0, in_data.row_index};
      fg     <= in_attr.reverse ? in_data.back_color : in_data.fore_color;
      bg     <= in_attr.reverse ? in_data.fore_color : in_data.back_color;
    end else if (emit_fire) begin
      rem    <= rem_next;
    end
  end

  `GAR_ASSERT_NOW(a_ready_when_busy, busy && s_tready, out_advance && rem_next == 9'd0, "row taken while writes remain")
  `GAR_ASSERT_NOW(a_busy_has_work, busy, rem != 9'd0, "emitter busy with no pending column")
  `GAR_ASSERT_NEXT(a_row_continues, m_tvalid && !m_tlast, m_tvalid, "row ended without last write")

endmodule

// File: test/tb_glyph_8x16_attribute_renderer.sv
// Testbench for the glyph row renderer: directed and random glyph rows checked against a predictor.
`timescale 1ns / 1ps

module tb_glyph_8x16_attribute_renderer;

  typedef struct {
    logic [3:0]         row;
    logic [7:0]         pattern;
    logic signed [12:0] x;
    logic signed [12:0] y;
    logic [15:0]        fg;
    logic [15:0]        bg;
    logic               rev;
    logic               frame;
    logic [1:0]         ul;
    logic [1:0]         shade;
    logic               transp;
    logic               bold;
  } glyph_line_t;

  typedef struct {
    logic [11:0] x;
    logic [11:0] y;
    logic [15:0] color;
    logic        last;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic [7:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic [12:0] width_cfg = glyph_pkg::ScreenWidthReset;
  logic [12:0] height_cfg = glyph_pkg::ScreenHeightReset;
  pixel_t      pixel_q[$];
  bit          src_idle = 1'b1;
  bit          sink_idle = 1'b1;
  int          sink_gap = 0;
  int          sink_draw = 0;
  int          fail_count = 0;
  int          rows_sent = 0;
  int          writes_checked = 0;
  int          sizes_tried = 0;
  glyph_pkg::out_data_t seen;
  pixel_t      want;

  glyph_8x16_attribute_renderer dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  initial begin
    #1_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (fail_count < 100) $display("mismatch at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic logic [7:0] shape_pattern(glyph_line_t it);
    logic [7:0] d;
    d = it.pattern;
    if (it.frame) begin
      if (it.row == 4'd0) d = glyph_pkg::RowFull;
      else d[0] = 1'b1;
    end
    if (it.ul == glyph_pkg::UL_DOUBLE) begin
      if (it.row == 4'd13 || it.row == 4'd15) d = glyph_pkg::RowFull;
    end else if (it.ul[0]) begin
      if (it.row == 4'd14 || it.row == 4'd15) d = glyph_pkg::RowFull;
    end
    if (it.shade == glyph_pkg::SH_CONCEAL)
      d = d | (it.row[0] ? glyph_pkg::MaskOdd : glyph_pkg::MaskEven);
    else if (it.shade[0])
      d = d & (it.row[0] ? glyph_pkg::MaskOdd : glyph_pkg::MaskEven);
    return d;
  endfunction

  function automatic void predict_pixels(glyph_line_t it);
    int         w, h, cx, cy, px, first;
    logic [7:0] d;
    logic [15:0] fg, bg;
    logic       own, left, lit;
    pixel_t     p;
    w = width_cfg;
    h = height_cfg;
    cx = it.x;
    cy = it.y;
    if (cx < 0 || cy < 0 || cx > w - 8 || cy > h - 16) return;
    fg = it.rev ? it.bg : it.fg;
    bg = it.rev ? it.fg : it.bg;
    d = shape_pattern(it);
    first = pixel_q.size();
    for (int c = 0; c < glyph_pkg::Columns; c++) begin
      own = (c < 8) ? d[7 - c] : 1'b0;
      left = (it.bold && c > 0) ? d[8 - c] : 1'b0;
      lit = own | left;
      px = cx + c;
      if (px >= w) continue;
      if (!lit && (c == 8 || it.transp)) continue;
      p.x = 12'(px);
      p.y = 12'(cy + int'(it.row));
      p.color = lit ? fg : bg;
      p.last = 1'b0;
      pixel_q.push_back(p);
    end
    if (pixel_q.size() > first) pixel_q[pixel_q.size() - 1].last = 1'b1;
  endfunction

  always @(posedge clk) begin
    if (sink_gap > 0) begin
      sink_gap <= sink_gap - 1;
      m_tready <= (sink_gap == 1);
    end else if (m_tready && m_tvalid && sink_idle) begin
      sink_draw = $urandom_range(0, 8);
      sink_gap <= sink_draw;
      m_tready <= (sink_draw == 0);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen = m_tdata;
      if (pixel_q.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel write x=%0d y=%0d color=%h",
                                  seen.pixel_x, seen.pixel_y, seen.pixel_color));
      end else begin
        want = pixel_q.pop_front();
        if (seen.pixel_x !== want.x)
          report_mismatch($sformatf("pixel_x %0d, want %0d", seen.pixel_x, want.x));
        if (seen.pixel_y !== want.y)
          report_mismatch($sformatf("pixel_y %0d, want %0d", seen.pixel_y, want.y));
        if (seen.pixel_color !== want.color)
          report_mismatch($sformatf("pixel_color %h, want %h", seen.pixel_color, want.color));
        if (m_tlast !== want.last)
          report_mismatch($sformatf("last_of_row %b, want %b", m_tlast, want.last));
        writes_checked++;
      end
    end
  end

  task automatic apb_write(input glyph_pkg::reg_idx_t idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_check(input glyph_pkg::reg_idx_t idx, input logic [12:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {19'd0, value})
      report_mismatch($sformatf("register %s reads %h, want %h", idx.name(), prdata, value));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_screen(input logic [31:0] w, input logic [31:0] h);
    apb_write(glyph_pkg::REG_SCREEN_WIDTH, w);
    apb_write(glyph_pkg::REG_SCREEN_HEIGHT, h);
    width_cfg = w[12:0];
    height_cfg = h[12:0];
    apb_check(glyph_pkg::REG_SCREEN_WIDTH, width_cfg);
    apb_check(glyph_pkg::REG_SCREEN_HEIGHT, height_cfg);
    sizes_tried++;
  endtask

  task automatic send_row(input glyph_line_t it);
    int                  gap;
    glyph_pkg::in_data_t d;
    glyph_pkg::in_attr_t a;
    gap = src_idle ? $urandom_range(0, 8) : 0;
    d.pad = '0;
    d.back_color = it.bg;
    d.fore_color = it.fg;
    d.cell_y = it.y;
    d.cell_x = it.x;
    d.glyph_row = it.pattern;
    d.row_index = it.row;
    a.bold = it.bold;
    a.transparent = it.transp;
    a.shade_mode = it.shade;
    a.underline_mode = it.ul;
    a.framed = it.frame;
    a.reverse = it.rev;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata <= d;
    s_tuser <= a;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    predict_pixels(it);
    rows_sent++;
  endtask

  task automatic drain_rows();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  function automatic glyph_line_t plain_row(logic [3:0] row, logic [7:0] pattern,
                                            int x, int y);
    glyph_line_t it;
    it.row = row;
    it.pattern = pattern;
    it.x = 13'(x);
    it.y = 13'(y);
    it.fg = 16'hffff;
    it.bg = 16'h0000;
    it.rev = 1'b0;
    it.frame = 1'b0;
    it.ul = glyph_pkg::UL_NONE;
    it.shade = glyph_pkg::SH_NONE;
    it.transp = 1'b0;
    it.bold = 1'b0;
    return it;
  endfunction

  function automatic int pick_origin(int span);
    int top;
    if (span < 0 || $urandom_range(0, 4) == 0) return int'($signed(13'($urandom)));
    top = (span > 4095) ? 4095 : span;
    case ($urandom_range(0, 5))
      0: return top;
      1: return (top > 0) ? top - 1 : 0;
      default: return $urandom_range(0, top);
    endcase
  endfunction

  function automatic glyph_line_t random_row();
    glyph_line_t it;
    it.row = 4'($urandom);
    it.pattern = ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom);
    it.x = 13'(pick_origin(int'(width_cfg) - 8));
    it.y = 13'(pick_origin(int'(height_cfg) - 16));
    it.fg = 16'($urandom);
    it.bg = 16'($urandom);
    it.rev = 1'($urandom);
    it.frame = ($urandom_range(0, 3) == 0);
    it.ul = 2'($urandom);
    it.shade = 2'($urandom);
    it.transp = 1'($urandom);
    it.bold = 1'($urandom);
    return it;
  endfunction

  task automatic test_register_reset();
    apb_check(glyph_pkg::REG_SCREEN_WIDTH, glyph_pkg::ScreenWidthReset);
    apb_check(glyph_pkg::REG_SCREEN_HEIGHT, glyph_pkg::ScreenHeightReset);
    sizes_tried++;
  endtask

  task automatic test_directed_rows();
    glyph_line_t it;
    send_row(plain_row(4'd0, 8'h00, 0, 0));
    it = plain_row(4'd15, 8'hff, 312, 224); it.fg = 16'h0000; it.bg = 16'hffff;
    it.bold = 1'b1; send_row(it);
    it = plain_row(4'd7, 8'h81, 311, 100); it.bold = 1'b1; send_row(it);
    it = plain_row(4'd2, 8'h55, 10, 10); it.bold = 1'b1; it.transp = 1'b1; send_row(it);
    it = plain_row(4'd3, 8'h00, 20, 10); it.transp = 1'b1; send_row(it);
    it = plain_row(4'd4, 8'hf0, 30, 10); it.rev = 1'b1; it.fg = 16'h1234;
    it.bg = 16'hedcb; send_row(it);
    it = plain_row(4'd0, 8'h00, 40, 40); it.frame = 1'b1; send_row(it);
    it = plain_row(4'd9, 8'h10, 40, 40); it.frame = 1'b1; send_row(it);
    for (int r = 13; r <= 15; r++) begin
      it = plain_row(4'(r), 8'h00, 50, 50); it.ul = glyph_pkg::UL_SINGLE; send_row(it);
      it.ul = glyph_pkg::UL_DOUBLE; send_row(it);
    end
    it = plain_row(4'd14, 8'h00, 60, 50); it.ul = 2'($urandom_range(3, 3)); send_row(it);
    it = plain_row(4'd2, 8'hff, 70, 50); it.shade = glyph_pkg::SH_DIM; send_row(it);
    it.row = 4'd3; send_row(it);
    it = plain_row(4'd4, 8'h00, 80, 50); it.shade = glyph_pkg::SH_CONCEAL; send_row(it);
    it.row = 4'd5; send_row(it);
    it = plain_row(4'd6, 8'hff, 90, 50); it.shade = 2'($urandom_range(3, 3)); send_row(it);
    it = plain_row(4'd15, 8'h00, 100, 60); it.frame = 1'b1; it.ul = glyph_pkg::UL_SINGLE;
    it.shade = glyph_pkg::SH_DIM; send_row(it);
    send_row(plain_row(4'd1, 8'hff, -1, 0));
    send_row(plain_row(4'd1, 8'hff, 0, -1));
    send_row(plain_row(4'd1, 8'hff, 313, 0));
    send_row(plain_row(4'd1, 8'hff, 0, 225));
    send_row(plain_row(4'd1, 8'hff, -4096, 0));
    send_row(plain_row(4'd1, 8'hff, 4095, 4095));
    drain_rows();
  endtask

  task automatic test_random_rows(input int count, input bit idle);
    src_idle = idle;
    sink_idle = idle;
    repeat (count) send_row(random_row());
    drain_rows();
    src_idle = 1'b1;
    sink_idle = 1'b1;
  endtask

  task automatic test_tiny_screens();
    glyph_line_t it;
    set_screen(32'd0, 32'd0);
    send_row(plain_row(4'd0, 8'hff, 0, 0));
    drain_rows();
    set_screen(32'd7, 32'd15);
    send_row(plain_row(4'd0, 8'hff, 0, 0));
    send_row(random_row());
    drain_rows();
    set_screen(32'd8, 32'd16);
    it = plain_row(4'd15, 8'h01, 0, 0); it.bold = 1'b1; send_row(it);
    send_row(plain_row(4'd0, 8'hff, 1, 0));
    send_row(plain_row(4'd0, 8'hff, 0, 1));
    drain_rows();
    test_random_rows(25, 1'b1);
  endtask

  task automatic test_wide_screen();
    glyph_line_t it;
    set_screen(32'd4096, 32'd4096);
    it = plain_row(4'd15, 8'hff, 4088, 4080); it.bold = 1'b1; send_row(it);
    drain_rows();
    test_random_rows(30, 1'b1);
    set_screen(32'd8191, 32'd8191);
    it = plain_row(4'd15, 8'hff, 4095, 4095); it.bold = 1'b1; send_row(it);
    it = plain_row(4'd8, 8'h0f, 4090, 4089); it.bold = 1'b1; send_row(it);
    drain_rows();
    test_random_rows(25, 1'b1);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_reset();
    test_directed_rows();
    test_random_rows(40, 1'b1);
    test_random_rows(20, 1'b0);
    set_screen(32'hffff_e280, 32'h8000_01e0);
    test_random_rows(40, 1'b1);
    test_tiny_screens();
    test_wide_screen();
    set_screen(32'd100, 32'd37);
    test_random_rows(20, 1'b1);
    $display("rows sent: %0d, pixel writes checked: %0d, screen sizes: %0d",
             rows_sent, writes_checked, sizes_tried);
    $display("covered attributes, clipping, bold ninth column and coordinate wrap");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+design
design/glyph_pkg.sv
design/glyph_8x16_attribute_renderer.sv
test/tb_glyph_8x16_attribute_renderer.sv
